@@ sv/mcwd_pkg.sv @@
// Package for the multi-client watchdog: beat payload structs, opcodes,
// register map and fixed widths. No dependencies.
package mcwd_pkg;

    // client numbers and the client count share one fixed width
    localparam int unsigned ID_W      = 5;
    localparam int unsigned COUNT_W   = 12;
    localparam int unsigned APB_AW    = 3;
    localparam int unsigned APB_DW    = 32;

    localparam logic [COUNT_W-1:0] RELOAD_RST = 12'hFFF;

    typedef enum logic [1:0] {
        OP_TICK     = 2'd0,
        OP_REGISTER = 2'd1,
        OP_CHECKIN  = 2'd2,
        OP_NOP      = 2'd3
    } t_opcode;

    // register index, taken from paddr bit 2
    typedef enum logic {
        REG_RELOAD = 1'b0,
        REG_ENABLE = 1'b1
    } t_reg_idx;

    typedef struct packed {
        t_opcode         opcode;
        logic [ID_W-1:0] client_id;
    } t_wd_in;

    typedef struct packed {
        logic [ID_W-1:0] assigned_id;
        logic            status;
        logic            kicked;
        logic            expired;
    } t_wd_out;

endpackage

@@ sv/multi_client_watchdog_core.sv @@
// Multi-client watchdog core: client table, check-in mask, prescaled
// down-counter and sticky expiry, with an APB-style register port.
// Depends on mcwd_pkg.
//
// Usage: each input beat (tick, register, check-in, nop) yields exactly one result
// beat. One beat is accepted every cycle while o_stall is low; its result appears
// in the output register in the next cycle. That single output register also sets
// the stall: o_stall rises only while a result sits in that register and i_stall holds
// it, so a stalled consumer backs up the producer in the same cycle. Clients
// register in order and get numbers 0..MAX_CLIENTS-1; once every registered
// client has checked in, the counter reloads and the mask clears (kick).
// Ticks go through a divide-by-PRESCALE prescaler; each wrap decrements the
// 12-bit counter while enabled, and reaching zero sets a sticky expired flag
// that only reset clears. Setting enable from 0 to 1 loads the counter from
// the reload register. Registers: reload count at byte 0, enable at byte 4;
// write them only while no beat is in flight.
module multi_client_watchdog_core
    import mcwd_pkg::*;
#(
    parameter int unsigned MAX_CLIENTS = 31,
    parameter int unsigned PRESCALE    = 256
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // item input channel
    input  logic              i_valid,
    output logic              o_stall,
    input  t_wd_in            i_in_data,
    // result output channel
    output logic              o_valid,
    input  logic              i_stall,
    output t_wd_out           o_out_data,
    // register port
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    localparam int unsigned PS_W = $clog2(PRESCALE);
    localparam logic [PS_W-1:0]  PS_LAST  = PS_W'(PRESCALE - 1);
    localparam logic [ID_W-1:0]  MAX_CNT  = ID_W'(MAX_CLIENTS);

    // state
    logic [COUNT_W-1:0]     r_reload;
    logic                   r_enable;
    logic [ID_W-1:0]        r_client_count, n_client_count;
    logic [MAX_CLIENTS-1:0] r_mask, n_mask;
    logic [PS_W-1:0]        r_prescale, n_prescale;
    logic [COUNT_W-1:0]     r_down, n_down;
    logic                   r_expired, n_expired;

    // result register
    logic                   r_out_valid;
    t_wd_out                r_out, n_out;

    logic                   w_accept;
    logic                   w_kick;
    logic                   w_cfg_wr;
    logic                   w_start;
    t_reg_idx               w_reg_idx;
    logic [MAX_CLIENTS-1:0] w_mask_set;
    logic [MAX_CLIENTS-1:0] w_valid_bits;

    // Stall the producer only while a result waits and the consumer stalls.
    assign o_stall  = r_out_valid & i_stall;
    assign w_accept = i_valid & ~o_stall;

    assign o_valid    = r_out_valid;
    assign o_out_data = r_out;

    // ---------------------------------------------------------------------
    // Item datapath: one short pass from the state registers to the
    // result register.
    // ---------------------------------------------------------------------
    always_comb begin
        n_client_count = r_client_count;
        n_mask         = r_mask;
        n_prescale     = r_prescale;
        n_down         = r_down;
        n_expired      = r_expired;
        w_kick         = 1'b0;
        w_mask_set     = '0;
        w_valid_bits   = '0;

        n_out             = '0;

        // Bits of clients that have been handed out so far.
        for (int i = 0; i < MAX_CLIENTS; i++) begin
            w_valid_bits[i] = (ID_W'(i) < r_client_count);
        end

        case (i_in_data.opcode)
            OP_TICK: begin
                // Prescaler runs regardless of enable; only the decrement
                // is gated.
                if (r_prescale == PS_LAST) begin
                    n_prescale = '0;
                    if (r_enable) begin
                        if (r_down != '0) begin
                            n_down = r_down - COUNT_W'(1);
                        end
                        if (n_down == '0) begin
                            n_expired = 1'b1;
                        end
                    end
                end else begin
                    n_prescale = r_prescale + PS_W'(1);
                end
            end
            OP_REGISTER: begin
                if (r_client_count < MAX_CNT) begin
                    for (int i = 0; i < MAX_CLIENTS; i++) begin
                        w_mask_set[i] = (ID_W'(i) == r_client_count);
                    end
                    n_out.assigned_id = r_client_count;
                    n_mask            = r_mask | w_mask_set;
                    n_client_count    = r_client_count + ID_W'(1);
                end else begin
                    // Table full: refuse, hold the count saturated.
                    n_out.status = 1'b1;
                end
            end
            OP_CHECKIN: begin
                // Numbers past the table are dropped; unregistered numbers
                // inside it still set their bit.
                if (i_in_data.client_id < MAX_CNT) begin
                    for (int i = 0; i < MAX_CLIENTS; i++) begin
                        w_mask_set[i] = (ID_W'(i) == i_in_data.client_id);
                    end
                    n_mask = r_mask | w_mask_set;
                    if (&(n_mask | ~w_valid_bits)) begin
                        w_kick = 1'b1;
                        n_mask = '0;
                        n_down = r_reload;
                    end
                end
            end
            default: begin
                // OP_NOP: nothing moves
            end
        endcase

        n_out.kicked  = w_kick;
        n_out.expired = n_expired;
    end

    // ---------------------------------------------------------------------
    // Register port
    // ---------------------------------------------------------------------
    assign pready    = 1'b1;
    assign w_cfg_wr  = psel & penable & pwrite;
    assign w_reg_idx = t_reg_idx'(paddr[2]);
    // Start: a 0 to 1 write of enable loads the counter.
    assign w_start   = w_cfg_wr & (w_reg_idx == REG_ENABLE) & pwdata[0] & ~r_enable;

    always_comb begin
        case (w_reg_idx)
            REG_RELOAD: prdata = APB_DW'(r_reload);
            REG_ENABLE: prdata = APB_DW'(r_enable);
            default:    prdata = '0;
        endcase
    end

    // ---------------------------------------------------------------------
    // State and result registers
    // ---------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_reload       <= RELOAD_RST;
            r_enable       <= 1'b0;
            r_client_count <= '0;
            r_mask         <= '0;
            r_prescale     <= '0;
            r_down         <= RELOAD_RST;
            r_expired      <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            if (w_accept) begin
                r_client_count <= n_client_count;
                r_mask         <= n_mask;
                r_prescale     <= n_prescale;
                r_expired      <= n_expired;
                r_out_valid    <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid    <= 1'b0;
            end

            // Users must write registers only while idle (not enforced); a start wins anyway.
            if (w_start) begin
                r_down <= r_reload;
            end else if (w_accept) begin
                r_down <= n_down;
            end

            if (w_cfg_wr) begin
                case (w_reg_idx)
                    REG_RELOAD: begin
                        r_reload <= pwdata[COUNT_W-1:0];
                    end
                    REG_ENABLE: begin
                        r_enable <= pwdata[0];
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_out <= n_out;
        end
    end

    // ---------------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------------
    a_expired_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_expired |=> r_expired)
        else $error("expired flag dropped without reset");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_client_count <= MAX_CNT)
        else $error("client count beyond table size");

    a_kick_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_kick && !w_cfg_wr) |=>
            (r_mask == '0 && r_down == $past(r_reload) && r_out.kicked))
        else $error("kick did not reload counter and clear mask");

    a_refuse_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.status) |-> (r_client_count == MAX_CNT))
        else $error("registration refused with room in the table");

    a_expired_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && n_expired && !r_expired) |=> (r_down == '0 || r_out.kicked))
        else $error("expiry raised with counter not at zero");

endmodule

@@ verif/multi_client_watchdog_core_test.sv @@
`timescale 1ns / 1ps
// Self-checking bench for multi_client_watchdog_core: random and directed beats,
// APB register writes with read-back, and a scoreboard that predicts every result.
// Depends on mcwd_pkg and the core RTL.

import mcwd_pkg::*;

localparam int unsigned WD_MAX_CLIENTS = 31;
localparam int unsigned WD_PRESCALE    = 256;

// Tracks the watchdog state and the queue of results still owed by the core.
class wd_scoreboard;
    logic [COUNT_W-1:0]        reload_val;
    logic                      enabled;
    logic [ID_W-1:0]           clients;
    logic [WD_MAX_CLIENTS-1:0] checkin_bits;
    logic [7:0]                prescale_cnt;
    logic [COUNT_W-1:0]        countdown;
    logic                      expired_flag;
    t_wd_out                   expected_results[$];
    int unsigned               mismatches;

    function new();
        reload_val   = RELOAD_RST;
        enabled      = 1'b0;
        clients      = '0;
        checkin_bits = '0;
        prescale_cnt = '0;
        countdown    = RELOAD_RST;
        expired_flag = 1'b0;
        mismatches   = 0;
    endfunction

    function void write_reg(t_reg_idx idx, logic [APB_DW-1:0] value);
        if (idx == REG_RELOAD) begin
            reload_val = value[COUNT_W-1:0];
        end else begin
            // rising enable restarts the countdown
            if (value[0] && !enabled)
                countdown = reload_val;
            enabled = value[0];
        end
    endfunction

    function logic [APB_DW-1:0] reg_value(t_reg_idx idx);
        return (idx == REG_RELOAD) ? APB_DW'(reload_val) : APB_DW'(enabled);
    endfunction

    function void check_reg(t_reg_idx idx, logic [APB_DW-1:0] got);
        logic [APB_DW-1:0] want;
        want = reg_value(idx);
        if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
                $display("register %s read-back: expected %h, got %h", idx.name(), want, got);
        end
    endfunction

    function void advance_prescaler();
        if (prescale_cnt == 8'(WD_PRESCALE - 1)) begin
            prescale_cnt = '0;
            if (enabled) begin
                if (countdown != 0)
                    countdown--;
                if (countdown == 0)
                    expired_flag = 1'b1;
            end
        end else begin
            prescale_cnt++;
        end
    endfunction

    // Apply one accepted input beat and queue the result it must produce.
    function void note_beat(t_wd_in beat);
        t_wd_out     res;
        logic [31:0] valid_bits;
        res = '0;
        case (beat.opcode)
            OP_TICK: advance_prescaler();
            OP_REGISTER: begin
                if (clients < WD_MAX_CLIENTS) begin
                    res.assigned_id       = clients;
                    checkin_bits[clients] = 1'b1;
                    clients++;
                end else begin
                    res.status = 1'b1;
                end
            end
            OP_CHECKIN: begin
                if (beat.client_id < WD_MAX_CLIENTS) begin
                    checkin_bits[beat.client_id] = 1'b1;
                    valid_bits = (32'd1 << clients) - 32'd1;
                    if ((checkin_bits & valid_bits[WD_MAX_CLIENTS-1:0]) ==
                            valid_bits[WD_MAX_CLIENTS-1:0]) begin
                        countdown    = reload_val;
                        checkin_bits = '0;
                        res.kicked   = 1'b1;
                    end
                end
            end
            default: ;
        endcase
        res.expired = expired_flag;
        expected_results.push_back(res);
    endfunction

    function void check_result(t_wd_out got);
        t_wd_out want;
        if (expected_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("result beat with none pending: id=%0d status=%0b kicked=%0b expired=%0b",
                         got.assigned_id, got.status, got.kicked, got.expired);
            return;
        end
        want = expected_results.pop_front();
        if (got.assigned_id !== want.assigned_id || got.status !== want.status ||
                got.kicked !== want.kicked || got.expired !== want.expired) begin
            mismatches++;
            if (mismatches <= 10)
                $display({"result beat differs: expected id=%0d status=%0b kicked=%0b ",
                          "expired=%0b, got id=%0d status=%0b kicked=%0b expired=%0b"},
                         want.assigned_id, want.status, want.kicked, want.expired,
                         got.assigned_id, got.status, got.kicked, got.expired);
        end
    endfunction
endclass

module multi_client_watchdog_core_test;

    localparam int unsigned CYCLE_LIMIT = 500_000;
    localparam int unsigned HOLD_CYCLES = 300;

    // Per-phase sender idle and receiver stall odds, in percent.
    localparam int SEND_IDLE [6]   = '{0, 76, 0, 21, 0, 21};
    localparam int STALL_PCT [6]   = '{0, 0, 76, 21, 0, 21};
    localparam int PHASE_ITEMS [6] = '{190, 190, 190, 190, 400, 190};

    logic              i_clk;
    logic              i_rst_n    = 1'b0;
    logic              i_valid    = 1'b0;
    logic              o_stall;
    t_wd_in            i_in_data  = '0;
    logic              o_valid;
    logic              i_stall    = 1'b0;
    t_wd_out           o_out_data;
    logic              psel       = 1'b0;
    logic              penable    = 1'b0;
    logic              pwrite     = 1'b0;
    logic [APB_AW-1:0] paddr      = '0;
    logic [APB_DW-1:0] pwdata     = '0;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    wd_scoreboard sb = new();

    int          send_idle_pct = 0;
    int          stall_pct     = 0;
    int unsigned holds_asked   = 0;
    int unsigned holds_granted = 0;
    int unsigned hold_left     = 0;
    int unsigned cycle_count   = 0;

    multi_client_watchdog_core u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_in_data  (i_in_data),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_out_data (o_out_data),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Give up on a hung run.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Receiver: a requested hold-off wins over the random stall odds.
    always @(posedge i_clk) begin
        if (holds_granted != holds_asked) begin
            holds_granted <= holds_asked;
            hold_left     <= HOLD_CYCLES;
            i_stall       <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            i_stall   <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // Monitors: note each accepted input beat, check each accepted result beat.
    always @(posedge i_clk) begin
        if (i_rst_n && i_valid && !o_stall)
            sb.note_beat(i_in_data);
        if (i_rst_n && o_valid && !i_stall)
            sb.check_result(o_out_data);
    end

    function automatic t_wd_in mk_beat(t_opcode op, logic [ID_W-1:0] id);
        t_wd_in b;
        b.opcode    = op;
        b.client_id = id;
        return b;
    endfunction

    // Offer one beat, idling first at the phase odds, and hold it until taken.
    task automatic send_beat(input t_wd_in beat);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_in_data <= beat;
        @(posedge i_clk);
        while (o_stall)
            @(posedge i_clk);
    endtask

    // Drop valid and wait until every owed result has come back. The first
    // edge lets the monitor note the last accepted beat.
    task automatic settle();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.expected_results.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Setup and access cycles of a write, then read the register back.
    task automatic reg_write(input t_reg_idx idx, input logic [APB_DW-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready)
            @(posedge i_clk);
        sb.write_reg(idx, value);
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready)
            @(posedge i_clk);
        sb.check_reg(idx, prdata);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    // Empty table check-in, out-of-range id, unused opcode, unregistered
    // check-in, repeated check-ins and kicks with an empty table and with two clients.
    task automatic run_directed();
        send_beat(mk_beat(OP_CHECKIN, 5'd5));
        send_beat(mk_beat(OP_CHECKIN, 5'd31));
        send_beat(mk_beat(OP_NOP, 5'd31));
        send_beat(mk_beat(OP_TICK, 5'd0));
        send_beat(mk_beat(OP_REGISTER, 5'd31));
        send_beat(mk_beat(OP_REGISTER, 5'd0));
        send_beat(mk_beat(OP_CHECKIN, 5'd30));
        send_beat(mk_beat(OP_CHECKIN, 5'd0));
        send_beat(mk_beat(OP_CHECKIN, 5'd0));
        send_beat(mk_beat(OP_CHECKIN, 5'd1));
        send_beat(mk_beat(OP_REGISTER, 5'd17));
        send_beat(mk_beat(OP_CHECKIN, 5'd31));
        send_beat(mk_beat(OP_CHECKIN, 5'd1));
        send_beat(mk_beat(OP_CHECKIN, 5'd0));
        send_beat(mk_beat(OP_TICK, 5'd31));
        send_beat(mk_beat(OP_TICK, 5'd10));
        send_beat(mk_beat(OP_NOP, 5'd0));
        send_beat(mk_beat(OP_CHECKIN, 5'd30));
        send_beat(mk_beat(OP_REGISTER, 5'd21));
    endtask

    // Random traffic: tick bursts, full check-in rounds (some with a client
    // left out), registrations and loose noise beats.
    task automatic run_random(input int unsigned count);
        int unsigned     sent;
        int unsigned     pick;
        int unsigned     n;
        int unsigned     j;
        bit              broken;
        logic [ID_W-1:0] order [WD_MAX_CLIENTS];
        logic [ID_W-1:0] tmp;
        sent = 0;
        while (sent < count) begin
            pick = $urandom_range(99);
            if (pick < 30) begin
                n = $urandom_range(64, 1);
                if (n > count - sent)
                    n = count - sent;
                repeat (n) begin
                    send_beat(mk_beat(OP_TICK, ID_W'($urandom)));
                    sent++;
                end
            end else if (pick < 55) begin
                n = sb.clients;
                if (n == 0) begin
                    send_beat(mk_beat(OP_CHECKIN, ID_W'($urandom_range(30))));
                    sent++;
                end else begin
                    for (int k = 0; k < n; k++)
                        order[k] = ID_W'(k);
                    for (int k = n - 1; k > 0; k--) begin
                        j        = $urandom_range(k);
                        tmp      = order[k];
                        order[k] = order[j];
                        order[j] = tmp;
                    end
                    broken = ($urandom_range(5) == 0);
                    for (int k = 0; k < n - broken; k++) begin
                        if ($urandom_range(7) == 0) begin
                            send_beat(mk_beat(OP_TICK, ID_W'($urandom)));
                            sent++;
                        end
                        send_beat(mk_beat(OP_CHECKIN, order[k]));
                        sent++;
                    end
                end
            end else if (pick < 70) begin
                repeat ($urandom_range(3, 1)) begin
                    send_beat(mk_beat(OP_REGISTER, ID_W'($urandom)));
                    sent++;
                end
            end else if (pick < 82) begin
                send_beat(mk_beat(OP_CHECKIN, ID_W'($urandom_range(31))));
                sent++;
            end else if (pick < 88) begin
                send_beat(mk_beat(OP_NOP, ID_W'($urandom)));
                sent++;
            end else begin
                send_beat(mk_beat(t_opcode'($urandom_range(3)), ID_W'($urandom)));
                sent++;
            end
        end
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int ph = 0; ph < 6; ph++) begin
            // registers change only with the core drained
            settle();
            case (ph)
                0: begin
                    reg_write(REG_RELOAD, 32'h0000_0FFF);
                    reg_write(REG_ENABLE, 32'd0);
                end
                1: begin
                    reg_write(REG_RELOAD, 32'd2048);
                    reg_write(REG_ENABLE, 32'd1);
                end
                2: begin
                    // reload alone leaves the running count; enable stays set
                    reg_write(REG_RELOAD, 32'd4000);
                    reg_write(REG_ENABLE, 32'd1);
                end
                3: begin
                    reg_write(REG_ENABLE, 32'd0);
                    reg_write(REG_RELOAD, 32'd7);
                end
                4: begin
                    // zero reload: the next prescaler wrap raises expiry
                    reg_write(REG_RELOAD, 32'd0);
                    reg_write(REG_ENABLE, 32'd1);
                end
                default: begin
                    reg_write(REG_ENABLE, 32'd0);
                    reg_write(REG_RELOAD, 32'hFFFF_FFFF);
                    reg_write(REG_ENABLE, 32'hFFFF_FFFF);
                end
            endcase
            send_idle_pct = SEND_IDLE[ph];
            stall_pct    <= STALL_PCT[ph];

            if (ph == 0) begin
                run_directed();
                // long receiver hold-off while beats keep coming: back up the core
                holds_asked <= holds_asked + 1;
            end
            if (ph == 1) begin
                // pause the sender mid-phase until every result is back
                run_random(PHASE_ITEMS[ph] / 2);
                settle();
                run_random(PHASE_ITEMS[ph] - PHASE_ITEMS[ph] / 2);
            end else begin
                run_random(PHASE_ITEMS[ph]);
            end
        end

        settle();
        if (sb.mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
